### rtl/imu_fp_pkg.sv
// package: frame layout constants, register indexes, frame record type and a magnitude helper
package imu_fp_pkg;

	localparam int unsigned POS_W   = 6;
	localparam int unsigned THR_W   = 17;
	localparam int unsigned REG_IDX_W = 2;

	typedef logic [POS_W-1:0] imu_fp_pos_t;
	typedef logic [REG_IDX_W-1:0] imu_fp_reg_idx_t;

	localparam logic [7:0] SYNC_A = 8'h55;
	localparam logic [7:0] SYNC_B = 8'h50;

	localparam imu_fp_pos_t POS_SYNC_A   = 6'd0;
	localparam imu_fp_pos_t POS_SYNC_B   = 6'd1;
	localparam imu_fp_pos_t POS_HOUR     = 6'd5;
	localparam imu_fp_pos_t POS_MINUTE   = 6'd6;
	localparam imu_fp_pos_t POS_SECOND   = 6'd7;
	localparam imu_fp_pos_t POS_MS_LO    = 6'd8;
	localparam imu_fp_pos_t POS_MS_HI    = 6'd9;
	localparam imu_fp_pos_t POS_CHK0     = 6'd10;
	localparam imu_fp_pos_t POS_SUB1     = 6'd11;
	localparam imu_fp_pos_t POS_AX_LO    = 6'd13;
	localparam imu_fp_pos_t POS_AX_HI    = 6'd14;
	localparam imu_fp_pos_t POS_AY_LO    = 6'd15;
	localparam imu_fp_pos_t POS_AY_HI    = 6'd16;
	localparam imu_fp_pos_t POS_AZ_LO    = 6'd17;
	localparam imu_fp_pos_t POS_AZ_HI    = 6'd18;
	localparam imu_fp_pos_t POS_CHK1     = 6'd21;
	localparam imu_fp_pos_t POS_SUB2     = 6'd22;
	localparam imu_fp_pos_t POS_GX_LO    = 6'd24;
	localparam imu_fp_pos_t POS_GX_HI    = 6'd25;
	localparam imu_fp_pos_t POS_GY_LO    = 6'd26;
	localparam imu_fp_pos_t POS_GY_HI    = 6'd27;
	localparam imu_fp_pos_t POS_GZ_LO    = 6'd28;
	localparam imu_fp_pos_t POS_GZ_HI    = 6'd29;
	localparam imu_fp_pos_t POS_CHK2     = 6'd32;
	localparam imu_fp_pos_t POS_FRAME_LEN = 6'd33;

	localparam imu_fp_reg_idx_t REG_LAUNCH    = 2'd0;
	localparam imu_fp_reg_idx_t REG_STEADY_LO = 2'd1;
	localparam imu_fp_reg_idx_t REG_STEADY_HI = 2'd2;

	localparam logic [THR_W-1:0] LAUNCH_RST    = 17'd10240;
	localparam logic [THR_W-1:0] STEADY_LO_RST = 17'd1638;
	localparam logic [THR_W-1:0] STEADY_HI_RST = 17'd6144;

	typedef struct packed {
		logic [7:0]         hour;
		logic [7:0]         minute;
		logic [7:0]         second;
		logic [15:0]        millisecond;
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] angle_x;
		logic signed [15:0] angle_y;
		logic signed [15:0] angle_z;
	} imu_fp_frame_t;

	function automatic logic [THR_W-1:0] abs_mag(input logic signed [15:0] v);
		logic [THR_W-1:0] e;
		e = {v[15], v};
		return v[15] ? (~e + 17'd1) : e;
	endfunction

endpackage

### rtl/imu_fp_if.sv
// channel interfaces: byte input, register write and result output
interface imu_fp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface imu_fp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface imu_fp_result_if;
	logic               valid;
	logic               ready;
	logic [7:0]         hour;
	logic [7:0]         minute;
	logic [7:0]         second;
	logic [15:0]        millisecond;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] angle_x;
	logic signed [15:0] angle_y;
	logic signed [15:0] angle_z;
	logic [16:0]        accel_abs_sum;
	logic [1:0]         motion_flags;

	modport source (output valid, output hour, output minute, output second,
		output millisecond, output accel_x, output accel_y, output accel_z,
		output angle_x, output angle_y, output angle_z, output accel_abs_sum,
		output motion_flags, input ready);
	modport sink (input valid, input hour, input minute, input second,
		input millisecond, input accel_x, input accel_y, input accel_z,
		input angle_x, input angle_y, input angle_z, input accel_abs_sum,
		input motion_flags, output ready);
endinterface

### rtl/imu_frame_parser_motion_detect.sv
// top level: serial frame parser with sum checks and motion flags
//
// rx carries one serial byte per word. The parser hunts for 0x55 then 0x50,
// collects the rest of a 33-byte frame and checks the sum byte of each of
// its three subpackets. A frame that fails is dropped with no result.
// res carries one word per good frame: time, raw acceleration and angle
// counts, the acceleration magnitude sum and the launched/steady flags.
// cfg writes the three thresholds (index 0 launch, 1 steady low, 2 steady
// high); it is always ready, index 3 is ignored.
// Throughput: one byte per cycle while rx.ready holds, set by the position counter
// and running sums that take a byte each cycle; one result per 33 bytes at most.
// The last byte of a frame passes the input register, parser, magnitude sum
// and result registers in that order before res is valid.
// Reset clears the position to sync hunt, the sums and all valid bits and
// loads the threshold defaults. When res stalls, up to two finished frames
// wait in the pipeline and bytes keep flowing until a third frame
// completes; then rx.ready drops until res takes a word.
module imu_frame_parser_motion_detect (
	input  logic            clk,
	input  logic            arst_n,
	imu_fp_byte_if.sink     rx,
	imu_fp_cfg_if.sink      cfg,
	imu_fp_result_if.source res
);
	import imu_fp_pkg::*;

	logic          frame_valid;
	logic          frame_ready;
	imu_fp_frame_t frame;

	imu_fp_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx),
		.frame_valid (frame_valid),
		.frame       (frame),
		.frame_ready (frame_ready)
	);

	imu_fp_motion u_motion (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.frame_valid (frame_valid),
		.frame       (frame),
		.frame_ready (frame_ready),
		.res         (res)
	);

endmodule

### rtl/imu_fp_parser.sv
// frame parser: sync hunt, byte capture, running subpacket sums and checks
module imu_fp_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	imu_fp_byte_if.sink            rx,
	output logic                   frame_valid,
	output imu_fp_pkg::imu_fp_frame_t frame,
	input  logic                   frame_ready
);
	import imu_fp_pkg::*;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	imu_fp_pos_t   pos_q;
	logic [7:0]    sum0_q, sum1_q, sum2_q;
	logic          chk_q;
	logic          frame_valid_s2;
	imu_fp_frame_t frame_s2;
	imu_fp_frame_t cap_q;
	logic          s2_free;
	logic          consume;
	logic          in_body;
	logic          summed;
	logic          emit;

	assign s2_free  = !frame_valid_s2 || frame_ready;
	assign consume  = valid_s1 && s2_free;
	assign rx.ready = !valid_s1 || consume;

	assign in_body = (pos_q >= 6'd2) && (pos_q < POS_FRAME_LEN);
	assign summed  = in_body && (pos_q != POS_CHK0) && (pos_q != POS_CHK1) &&
		(pos_q != POS_CHK2);
	assign emit    = (pos_q == POS_CHK2) && chk_q && (byte_s1 == sum2_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			pos_q          <= POS_SYNC_A;
			sum0_q         <= 8'd0;
			sum1_q         <= 8'd0;
			sum2_q         <= 8'd0;
			chk_q          <= 1'b0;
			frame_valid_s2 <= 1'b0;
		end else begin
			if (rx.ready) begin
				valid_s1 <= rx.valid;
			end
			if (consume && emit) begin
				frame_valid_s2 <= 1'b1;
			end else if (frame_ready) begin
				frame_valid_s2 <= 1'b0;
			end
			if (consume) begin
				if (pos_q == POS_SYNC_A) begin
					if (byte_s1 == SYNC_A) begin
						sum0_q <= SYNC_A;
						sum1_q <= 8'd0;
						sum2_q <= 8'd0;
						pos_q  <= POS_SYNC_B;
					end
				end else if (pos_q == POS_SYNC_B) begin
					if (byte_s1 == SYNC_B) begin
						sum0_q <= sum0_q + byte_s1;
						pos_q  <= pos_q + 6'd1;
					end else begin
						pos_q <= POS_SYNC_A;
					end
				end else if (pos_q >= POS_CHK2) begin
					pos_q <= POS_SYNC_A;
				end else begin
					pos_q <= pos_q + 6'd1;
				end
				if (summed) begin
					if (pos_q < POS_SUB1) begin
						sum0_q <= sum0_q + byte_s1;
					end else if (pos_q < POS_SUB2) begin
						sum1_q <= sum1_q + byte_s1;
					end else begin
						sum2_q <= sum2_q + byte_s1;
					end
				end
				if (pos_q == POS_CHK0) begin
					chk_q <= (byte_s1 == sum0_q);
				end else if (pos_q == POS_CHK1) begin
					chk_q <= chk_q && (byte_s1 == sum1_q);
				end
			end
		end
	end

	// payload: input byte, captured fields and the frame record
	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
		if (consume) begin
			case (pos_q)
				POS_HOUR:   cap_q.hour               <= byte_s1;
				POS_MINUTE: cap_q.minute             <= byte_s1;
				POS_SECOND: cap_q.second             <= byte_s1;
				POS_MS_LO:  cap_q.millisecond[7:0]   <= byte_s1;
				POS_MS_HI:  cap_q.millisecond[15:8]  <= byte_s1;
				POS_AX_LO:  cap_q.accel_x[7:0]       <= byte_s1;
				POS_AX_HI:  cap_q.accel_x[15:8]      <= byte_s1;
				POS_AY_LO:  cap_q.accel_y[7:0]       <= byte_s1;
				POS_AY_HI:  cap_q.accel_y[15:8]      <= byte_s1;
				POS_AZ_LO:  cap_q.accel_z[7:0]       <= byte_s1;
				POS_AZ_HI:  cap_q.accel_z[15:8]      <= byte_s1;
				POS_GX_LO:  cap_q.angle_x[7:0]       <= byte_s1;
				POS_GX_HI:  cap_q.angle_x[15:8]      <= byte_s1;
				POS_GY_LO:  cap_q.angle_y[7:0]       <= byte_s1;
				POS_GY_HI:  cap_q.angle_y[15:8]      <= byte_s1;
				POS_GZ_LO:  cap_q.angle_z[7:0]       <= byte_s1;
				POS_GZ_HI:  cap_q.angle_z[15:8]      <= byte_s1;
				default: ;
			endcase
			if (emit) begin
				frame_s2 <= cap_q;
			end
		end
	end

	assign frame_valid = frame_valid_s2;
	assign frame       = frame_s2;

endmodule

### rtl/imu_fp_motion.sv
// motion stage: threshold registers, acceleration magnitude sum, flags, result register
module imu_fp_motion (
	input  logic                      clk,
	input  logic                      arst_n,
	imu_fp_cfg_if.sink                cfg,
	input  logic                      frame_valid,
	input  imu_fp_pkg::imu_fp_frame_t frame,
	output logic                      frame_ready,
	imu_fp_result_if.source           res
);
	import imu_fp_pkg::*;

	logic [THR_W-1:0] launch_q, steady_lo_q, steady_hi_q;
	logic             valid_s3;
	imu_fp_frame_t    frame_s3;
	logic [THR_W-1:0] sum_s3;
	logic             out_valid_q;
	imu_fp_frame_t    out_frame_q;
	logic [THR_W-1:0] out_sum_q;
	logic [1:0]       out_flags_q;
	logic             out_free;
	logic             s3_free;
	logic [THR_W-1:0] abs_sum;
	logic [1:0]       flags;

	assign out_free    = !out_valid_q || res.ready;
	assign s3_free     = !valid_s3 || out_free;
	assign frame_ready = s3_free;
	assign cfg.ready   = 1'b1;

	assign abs_sum = abs_mag(frame.accel_x) + abs_mag(frame.accel_y) +
		abs_mag(frame.accel_z);

	always_comb begin
		flags    = 2'b00;
		flags[0] = sum_s3 > launch_q;
		flags[1] = (sum_s3 > steady_lo_q) && (sum_s3 < steady_hi_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q    <= LAUNCH_RST;
			steady_lo_q <= STEADY_LO_RST;
			steady_hi_q <= STEADY_HI_RST;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_LAUNCH:    launch_q    <= cfg.data;
					REG_STEADY_LO: steady_lo_q <= cfg.data;
					REG_STEADY_HI: steady_hi_q <= cfg.data;
					default: ;
				endcase
			end
			if (s3_free) begin
				valid_s3 <= frame_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s3_free && frame_valid) begin
			frame_s3 <= frame;
			sum_s3   <= abs_sum;
		end
		if (out_free && valid_s3) begin
			out_frame_q <= frame_s3;
			out_sum_q   <= sum_s3;
			out_flags_q <= flags;
		end
	end

	assign res.valid         = out_valid_q;
	assign res.hour          = out_frame_q.hour;
	assign res.minute        = out_frame_q.minute;
	assign res.second        = out_frame_q.second;
	assign res.millisecond   = out_frame_q.millisecond;
	assign res.accel_x       = out_frame_q.accel_x;
	assign res.accel_y       = out_frame_q.accel_y;
	assign res.accel_z       = out_frame_q.accel_z;
	assign res.angle_x       = out_frame_q.angle_x;
	assign res.angle_y       = out_frame_q.angle_y;
	assign res.angle_z       = out_frame_q.angle_z;
	assign res.accel_abs_sum = out_sum_q;
	assign res.motion_flags  = out_flags_q;

endmodule

### rtl/imu_fp_checker.sv
// port checker for the frame parser top level, with its bind
module imu_fp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               rx_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic signed [15:0] accel_x,
	input logic signed [15:0] accel_y,
	input logic signed [15:0] accel_z,
	input logic [16:0]        accel_abs_sum,
	input logic [1:0]         motion_flags
);
	import imu_fp_pkg::*;

	logic [THR_W-1:0] exp_sum;

	assign exp_sum = abs_mag(accel_x) + abs_mag(accel_y) + abs_mag(accel_z);

	// stalled word stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(accel_abs_sum) && $stable(motion_flags))
		else $error("result word changed while stalled");

	// magnitude sum matches the acceleration fields
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> accel_abs_sum == exp_sum)
		else $error("accel_abs_sum does not match acceleration fields");

	// input never blocks while the result register is empty
	a_rx_open: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> rx_ready)
		else $error("input stalled with empty result register");

endmodule

bind imu_frame_parser_motion_detect imu_fp_checker u_imu_fp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_ready      (rx.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.accel_x       (res.accel_x),
	.accel_y       (res.accel_y),
	.accel_z       (res.accel_z),
	.accel_abs_sum (res.accel_abs_sum),
	.motion_flags  (res.motion_flags)
);
